// ----- design/oets_pkg.sv -----
// Shared types, sizes and command/state encodings for the odd-even transposition sorter.
// No dependencies; used by oets_ctrl, oets_dpath and the top level.
package oets_pkg;

	localparam int SIZE      = 64;
	localparam int KEY_W     = 17;
	localparam int COUNT_W   = $clog2(SIZE + 1);
	localparam int TDATA_W   = ((KEY_W + 7) / 8) * 8;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic   load;
		logic   sort;
		logic   odd;
		logic   shift_out;
		count_t held;
	} dp_cmd_t;

endpackage

// ----- design/oets_ctrl.sv -----
// Controller for the odd-even transposition sorter: load, sort and emit sequencing.
// Depends on oets_pkg; drives the command struct of oets_dpath.
module oets_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_final,
	output logic             in_ready,
	output logic             out_valid,
	output logic             out_last,
	input  logic             out_ready,
	output oets_pkg::dp_cmd_t cmd
);
	import oets_pkg::*;

	state_t state_q, state_d;
	count_t held_q, held_d;
	count_t phase_q, phase_d;
	count_t held_inc, phase_inc;

	assign held_inc  = held_q + count_t'(1);
	assign phase_inc = phase_q + count_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			held_q  <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		held_d        = held_q;
		phase_d       = phase_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		out_last      = 1'b0;
		cmd.load      = 1'b0;
		cmd.sort      = 1'b0;
		cmd.odd       = phase_q[0];
		cmd.shift_out = 1'b0;
		cmd.held      = held_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					held_d   = held_inc;
					phase_d  = '0;
					if (in_final || held_inc == count_t'(SIZE)) begin
						state_d = ST_SORT;
					end
				end
			end
			ST_SORT: begin
				cmd.sort = 1'b1;
				if (phase_inc == held_q) begin
					phase_d = '0;
					state_d = ST_EMIT;
				end else begin
					phase_d = phase_inc;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_last  = (phase_inc == held_q);
				if (out_ready) begin
					cmd.shift_out = 1'b1;
					if (out_last) begin
						phase_d = '0;
						held_d  = '0;
						state_d = ST_LOAD;
					end else begin
						phase_d = phase_inc;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// ----- design/oets_dpath.sv -----
// Datapath for the odd-even transposition sorter: a row of key cells with shift-in,
// one compare-exchange phase per cycle and shift-out. Depends on oets_pkg.
module oets_dpath (
	input  logic              clk,
	input  oets_pkg::dp_cmd_t cmd,
	input  oets_pkg::key_t    in_key,
	output oets_pkg::key_t    head_key
);
	import oets_pkg::*;

	key_t cell_q [SIZE];
	key_t cell_d [SIZE];
	logic pair_en [SIZE];
	logic pair_swap [SIZE];

	always_comb begin
		for (int i = 0; i < SIZE; i++) begin
			pair_en[i]   = 1'b0;
			pair_swap[i] = 1'b0;
		end
		for (int i = 0; i < SIZE - 1; i++) begin
			pair_en[i]   = (i[0] == cmd.odd) && (count_t'(i + 1) < cmd.held);
			pair_swap[i] = pair_en[i] && (cell_q[i] > cell_q[i+1]);
		end
	end

	always_comb begin
		for (int i = 0; i < SIZE; i++) begin
			cell_d[i] = cell_q[i];
			if (cmd.load) begin
				cell_d[i] = (i == 0) ? in_key : cell_q[(i == 0) ? 0 : i - 1];
			end else if (cmd.shift_out) begin
				cell_d[i] = cell_q[(i == SIZE - 1) ? i : i + 1];
			end else if (cmd.sort) begin
				if (i < SIZE - 1 && pair_swap[i]) begin
					cell_d[i] = cell_q[(i < SIZE - 1) ? i + 1 : i];
				end else if (i > 0 && pair_swap[(i > 0) ? i - 1 : 0]) begin
					cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SIZE; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	assign head_key = cell_q[0];

endmodule

// ----- design/odd_even_transposition_sorter_unit.sv -----
// Odd-even transposition sorter. Keys enter one per transaction on the slave side; a
// transaction with tlast, or the SIZE-th key, closes the set. A set of n keys then goes
// through n compare-exchange phases, one per cycle across the held keys, and is
// returned in ascending order, one key per transaction, with tlast high on the largest.
// Loading and emitting move one key per accepted transaction; the input is not ready
// while a set sorts or drains.
// Depends on oets_pkg, oets_ctrl and oets_dpath.
module odd_even_transposition_sorter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [oets_pkg::TDATA_W-1:0]  s_tdata,  // [16:0] key, rest zero
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [oets_pkg::TDATA_W-1:0]  m_tdata,  // [16:0] sorted_key, rest zero
	output logic                          m_tlast
);
	import oets_pkg::*;

	dp_cmd_t cmd;
	key_t    head_key;

	oets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_final  (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	oets_dpath u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.in_key   (s_tdata[KEY_W-1:0]),
		.head_key (head_key)
	);

	assign m_tdata = TDATA_W'(head_key);

endmodule

// ----- tb/testbench.sv -----
// Testbench for odd_even_transposition_sorter_unit: streams key sets in, checks the sorted
// keys and the end-of-set flag against a transaction-level odd-even transposition sort.
// Depends on oets_pkg and the RTL of the unit; reads nothing at run time.
`timescale 1ns / 100ps

class sorted_key_board;
	oets_pkg::key_t held_keys[oets_pkg::SIZE];
	int unsigned    held_count;
	oets_pkg::key_t expected_keys[$];
	logic           expected_ends[$];
	int unsigned    errors;

	function void note_key(oets_pkg::key_t k, logic last);
		oets_pkg::key_t tmp;
		int unsigned    ph;
		int unsigned    i;
		held_keys[held_count] = k;
		held_count++;
		if (!last && held_count < oets_pkg::SIZE)
			return;
		for (ph = 0; ph < held_count; ph++) begin
			for (i = ph % 2; i + 1 < held_count; i += 2) begin
				if (held_keys[i] > held_keys[i+1]) begin
					tmp            = held_keys[i];
					held_keys[i]   = held_keys[i+1];
					held_keys[i+1] = tmp;
				end
			end
		end
		for (i = 0; i < held_count; i++) begin
			expected_keys.push_back(held_keys[i]);
			expected_ends.push_back(i + 1 == held_count);
		end
		held_count = 0;
	endfunction

	function void check_sorted(oets_pkg::key_t k, logic eos);
		oets_pkg::key_t exp_k;
		logic           exp_e;
		if (expected_keys.size() == 0) begin
			$display("%0t: unexpected transaction, sorted_key %0d end_of_set %0b", $time, k, eos);
			errors++;
			return;
		end
		exp_k = expected_keys.pop_front();
		exp_e = expected_ends.pop_front();
		if (k !== exp_k) begin
			$display("%0t: sorted_key mismatch, expected %0d, actual %0d", $time, exp_k, k);
			errors++;
		end
		if (eos !== exp_e) begin
			$display("%0t: end_of_set mismatch, expected %0b, actual %0b", $time, exp_e, eos);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return expected_keys.size();
	endfunction
endclass

module testbench;
	import oets_pkg::*;

	localparam int PAD_W = TDATA_W - KEY_W;
	typedef logic [PAD_W-1:0] pad_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;

	int unsigned     send_idle = 0;
	int unsigned     recv_idle = 0;
	int unsigned     sent_count = 0;
	sorted_key_board sb = new();

	odd_even_transposition_sorter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** odd_even_transposition_sorter_unit: FAILED **");
		$finish;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_key(s_tdata[KEY_W-1:0], s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_sorted(m_tdata[KEY_W-1:0], m_tlast);
	end

	// call at a falling edge; returns at the falling edge after the transaction
	task automatic send_key(input key_t k, input logic last, input pad_t pad);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {pad, k};
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		sent_count++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic key_t random_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return key_t'($urandom_range(0, 7));
			default: return key_t'($urandom_range(0, (1 << KEY_W) - 1));
		endcase
	endfunction

	task automatic send_set(input int unsigned n_keys, input bit mark_end);
		int unsigned i;
		pad_t        pad;
		for (i = 0; i < n_keys; i++) begin
			pad = ($urandom_range(0, 3) == 0) ? pad_t'($urandom) : '0;
			send_key(random_key(), mark_end && (i + 1 == n_keys), pad);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned n_items);
		int unsigned stop_at;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_set(SIZE, $urandom_range(0, 1) == 1);
			else
				send_set($urandom_range(1, 16), 1'b1);
		end
	endtask

	initial begin
		int unsigned guard;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single keys at both extremes, then a pair of them in reversed order
		send_key('0, 1'b1, '0);
		send_key('1, 1'b1, '0);
		send_key('1, 1'b0, '0);
		send_key('0, 1'b1, '0);
		// equal keys stay in turn
		repeat (3) send_key(key_t'(7), 1'b0, '0);
		send_key(key_t'(7), 1'b1, '0);
		// reversed order, padding bits set
		send_key('1, 1'b0, '1);
		send_key(key_t'(65536), 1'b0, pad_t'('h55));
		send_key(key_t'(4096), 1'b0, pad_t'('h2A));
		send_key(key_t'(256), 1'b0, '1);
		send_key(key_t'(16), 1'b0, '0);
		send_key(key_t'(2), 1'b0, pad_t'('h01));
		send_key(key_t'(1), 1'b0, pad_t'('h40));
		send_key('0, 1'b1, '1);
		send_key(key_t'(3), 1'b0, '0);
		send_key('1, 1'b0, '0);
		send_key(key_t'(3), 1'b0, '0);
		send_key('0, 1'b0, '0);
		send_key(key_t'(65535), 1'b1, '0);

		send_idle = 35;
		recv_idle = 82;
		// full store closes the set without tlast
		send_set(SIZE, 1'b0);
		run_phase(60);
		wait_drained();

		send_idle = 82;
		recv_idle = 35;
		run_phase(105);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		run_phase(105);

		guard = 0;
		while (sb.pending() != 0 && guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		repeat (200) @(negedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d sorted keys never arrived", $time, sb.pending());
			sb.errors += sb.pending();
		end

		if (sb.errors == 0)
			$display("** odd_even_transposition_sorter_unit: PASSED **");
		else
			$display("** odd_even_transposition_sorter_unit: FAILED **");
		$finish;
	end
endmodule

// ----- files.f -----
design/oets_pkg.sv
design/oets_ctrl.sv
design/oets_dpath.sv
design/odd_even_transposition_sorter_unit.sv
tb/testbench.sv
